@@ hdl/koch_curve_segment_generator_unit_macros.svh @@
// Assertion macros shared by the Koch curve segment generator RTL.
`ifndef KOCH_CURVE_SEGMENT_GENERATOR_UNIT_MACROS_SVH
`define KOCH_CURVE_SEGMENT_GENERATOR_UNIT_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define KCSG_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define KCSG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define KCSG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/kcsg_pkg.sv @@
// Types and constants of the Koch curve segment generator.
`default_nettype none

package kcsg_pkg;

  localparam int COORD_W       = 20;
  localparam int LEVEL_W       = 2;
  localparam int MAX_DEPTH_DEF = 3;

  localparam logic [LEVEL_W-1:0] KOCH_LEVEL_RESET = 2'd3;

  // APB decode: register index sits at byte address bit 2
  localparam int          CFG_ADDR_W     = 3;
  localparam int          CFG_DATA_W     = 32;
  localparam logic [0:0]  REG_KOCH_LEVEL = 1'b0;

  typedef logic signed [COORD_W-1:0] coord_t;

  localparam coord_t COORD_MAX = 20'sh7FFFF;
  localparam coord_t COORD_MIN = 20'sh80000;

  // floor(n/3) == (n * RECIP3) >> 21 for every n below 2^21
  localparam logic [19:0] RECIP3       = 20'd699051;
  localparam int          RECIP3_SHIFT = 21;
  // sqrt(3)/2 in Q0.16
  localparam logic [19:0] SQRT3_HALF   = 20'd56756;
  localparam int          SQRT3_SHIFT  = 16;

  localparam logic [1:0]  CHILD_LAST   = 2'd3;

  typedef struct packed {
    coord_t x1;
    coord_t y1;
    coord_t x2;
    coord_t y2;
  } kcsg_seg_t;

  typedef struct packed {
    coord_t xa;
    coord_t ya;
    coord_t xm;
    coord_t ym;
    coord_t xb;
    coord_t yb;
  } kcsg_pts_t;

  typedef struct packed {
    logic      done;
    kcsg_pts_t pts;
  } kcsg_split_rsp_t;

endpackage

`default_nettype wire

@@ hdl/kcsg_split.sv @@
// Iterative segment splitter: thirds and bump point over one shared multiplier.
`default_nettype none

module kcsg_split (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire kcsg_pkg::kcsg_seg_t       seg,
  output kcsg_pkg::kcsg_split_rsp_t      rsp
);

  typedef enum logic [6:0] {
    SP_IDLE = 7'b0000001,
    SP_DX   = 7'b0000010,
    SP_DY   = 7'b0000100,
    SP_AB   = 7'b0001000,
    SP_SX   = 7'b0010000,
    SP_SY   = 7'b0100000,
    SP_MP   = 7'b1000000
  } sp_state_t;

  sp_state_t state_r, state_nxt;

  logic                      sel_r, sel_nxt;   // 1: divide by 3, 0: sqrt(3)/2
  logic                      neg_r, neg_nxt;
  logic [39:0]               prod_r;
  logic signed [20:0]        op_diff;
  logic signed [20:0]        op_abs;
  logic [19:0]               op_mag;
  logic [19:0]               op_const;
  logic [19:0]               res_mag;
  logic signed [20:0]        res;

  logic signed [20:0]        dx_r, dy_r, sx_r;
  kcsg_pkg::coord_t          xa_r, ya_r, xb_r, yb_r, xm_r, ym_r;
  logic                      done_r;

  logic signed [20:0]        sum_x, sum_y, adj_x, adj_y;
  kcsg_pkg::coord_t          mx, my;

  function automatic kcsg_pkg::coord_t sat22(input logic signed [21:0] v);
    logic signed [21:0] hi;
    logic signed [21:0] lo;
    hi = 22'(kcsg_pkg::COORD_MAX);
    lo = 22'(kcsg_pkg::COORD_MIN);
    if (v > hi) begin
      return kcsg_pkg::COORD_MAX;
    end else if (v < lo) begin
      return kcsg_pkg::COORD_MIN;
    end else begin
      return v[kcsg_pkg::COORD_W-1:0];
    end
  endfunction

  // operand select for the shared multiplier
  always_comb begin
    op_diff = '0;
    sel_nxt = 1'b1;
    unique case (state_r)
      SP_IDLE: begin
        op_diff = 21'(seg.x2) - 21'(seg.x1);
        sel_nxt = 1'b1;
      end
      SP_DX: begin
        op_diff = 21'(seg.y2) - 21'(seg.y1);
        sel_nxt = 1'b1;
      end
      SP_SX: begin
        op_diff = 21'(yb_r) - 21'(ya_r);
        sel_nxt = 1'b0;
      end
      SP_SY: begin
        op_diff = 21'(xb_r) - 21'(xa_r);
        sel_nxt = 1'b0;
      end
      default: begin
        op_diff = '0;
        sel_nxt = 1'b1;
      end
    endcase
    neg_nxt  = op_diff[20];
    op_abs   = op_diff[20] ? -op_diff : op_diff;
    op_mag   = op_abs[19:0];
    op_const = sel_nxt ? kcsg_pkg::RECIP3 : kcsg_pkg::SQRT3_HALF;
  end

  // truncation toward zero: scale the magnitude, then restore the sign
  always_comb begin
    if (sel_r) begin
      res_mag = {1'b0, prod_r[39:kcsg_pkg::RECIP3_SHIFT]};
    end else begin
      res_mag = prod_r[kcsg_pkg::SQRT3_SHIFT+19:kcsg_pkg::SQRT3_SHIFT];
    end
    res = neg_r ? -$signed({1'b0, res_mag}) : $signed({1'b0, res_mag});
  end

  always_comb begin
    sum_x = 21'(xa_r) + 21'(xb_r);
    sum_y = 21'(ya_r) + 21'(yb_r);
    adj_x = sum_x + {20'd0, sum_x[20]};
    adj_y = sum_y + {20'd0, sum_y[20]};
    mx    = adj_x[20:1];
    my    = adj_y[20:1];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SP_IDLE: if (start) state_nxt = SP_DX;
      SP_DX:   state_nxt = SP_DY;
      SP_DY:   state_nxt = SP_AB;
      SP_AB:   state_nxt = SP_SX;
      SP_SX:   state_nxt = SP_SY;
      SP_SY:   state_nxt = SP_MP;
      SP_MP:   state_nxt = SP_IDLE;
      default: state_nxt = SP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SP_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == SP_MP);
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= {20'd0, op_mag} * {20'd0, op_const};
    sel_r  <= sel_nxt;
    neg_r  <= neg_nxt;
    if (state_r == SP_DX) dx_r <= res;
    if (state_r == SP_DY) dy_r <= res;
    if (state_r == SP_AB) begin
      xa_r <= sat22(22'(seg.x1) + 22'(dx_r));
      ya_r <= sat22(22'(seg.y1) + 22'(dy_r));
      xb_r <= sat22(22'(seg.x2) - 22'(dx_r));
      yb_r <= sat22(22'(seg.y2) - 22'(dy_r));
    end
    if (state_r == SP_SY) sx_r <= res;
    if (state_r == SP_MP) begin
      xm_r <= sat22(22'(mx) - 22'(sx_r));
      ym_r <= sat22(22'(my) + 22'(res));
    end
  end

  assign rsp.done   = done_r;
  assign rsp.pts.xa = xa_r;
  assign rsp.pts.ya = ya_r;
  assign rsp.pts.xm = xm_r;
  assign rsp.pts.ym = ym_r;
  assign rsp.pts.xb = xb_r;
  assign rsp.pts.yb = yb_r;

endmodule

`default_nettype wire

@@ hdl/koch_curve_segment_generator_unit.sv @@
// Koch curve segment generator: expands one segment into its 4^level Koch pieces.
// One input segment yields 4^L pieces, L = min(koch_level, MAX_DEPTH), emitted depth
// first, one at a time through a registered output; final_piece marks the last one.
// in_ready is high only between items. Each of the (4^L-1)/3 splits takes a descend
// step and then a run of the splitter on its shared multiplier, each piece a descend, an
// output and a step to the next sibling, and popping back up takes an ascend step for
// each split off the path to the last piece. Output stalls hold the block in its output
// step and delay the next item. koch_level sits at APB byte address 0; the user must
// write it only between items, as the block itself does not enforce this; pready is
// tied high.
`default_nettype none
`include "koch_curve_segment_generator_unit_macros.svh"

module koch_curve_segment_generator_unit #(
  parameter int MAX_DEPTH = kcsg_pkg::MAX_DEPTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire kcsg_pkg::coord_t                   in_start_x,
  input  wire kcsg_pkg::coord_t                   in_start_y,
  input  wire kcsg_pkg::coord_t                   in_end_x,
  input  wire kcsg_pkg::coord_t                   in_end_y,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output kcsg_pkg::coord_t                        out_piece_x1,
  output kcsg_pkg::coord_t                        out_piece_y1,
  output kcsg_pkg::coord_t                        out_piece_x2,
  output kcsg_pkg::coord_t                        out_piece_y2,
  output logic                                    out_final_piece,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [kcsg_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire logic [kcsg_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [kcsg_pkg::CFG_DATA_W-1:0]         prdata,
  output logic                                    pready
);

  localparam int STACK_D = MAX_DEPTH + 1;
  localparam int SP_W    = (MAX_DEPTH > 0) ? $clog2(MAX_DEPTH + 1) : 1;
  localparam int CNT_W   = 2 * MAX_DEPTH + 1;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_DESC  = 5'b00010,
    ST_SPLIT = 5'b00100,
    ST_OUT   = 5'b01000,
    ST_ASC   = 5'b10000
  } state_t;

  state_t                          state_r;
  logic [kcsg_pkg::LEVEL_W-1:0]    level_r;
  logic [SP_W-1:0]                 sp_r, lvl_r, lvl_clamp, sp_inc, sp_dec;
  logic [CNT_W-1:0]                cnt_r, total_r;
  logic [1:0]                      child_r [STACK_D];
  logic [1:0]                      k_nxt;
  kcsg_pkg::kcsg_seg_t             frame_r [STACK_D];
  kcsg_pkg::kcsg_pts_t             cache_r [STACK_D];
  kcsg_pkg::kcsg_seg_t             cur_seg, par_seg, next_seg;
  kcsg_pkg::kcsg_pts_t             par_pts;
  kcsg_pkg::kcsg_seg_t             out_seg_r;
  logic                            final_r;
  logic                            split_start;
  kcsg_pkg::kcsg_split_rsp_t       split_rsp;
  logic                            cfg_wr;
  logic                            in_fire, out_fire;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready &&
                    (paddr[2] == kcsg_pkg::REG_KOCH_LEVEL);
  assign prdata   = (paddr[2] == kcsg_pkg::REG_KOCH_LEVEL) ?
                    {{(kcsg_pkg::CFG_DATA_W-kcsg_pkg::LEVEL_W){1'b0}}, level_r} : '0;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;

  assign lvl_clamp = (level_r > kcsg_pkg::LEVEL_W'(MAX_DEPTH)) ?
                     SP_W'(MAX_DEPTH) : SP_W'(level_r);
  assign sp_inc    = sp_r + 1'b1;
  assign sp_dec    = sp_r - 1'b1;

  assign cur_seg   = frame_r[sp_r];
  assign par_seg   = frame_r[sp_dec];
  assign par_pts   = cache_r[sp_dec];
  assign k_nxt     = child_r[sp_dec] + 2'd1;

  // next sibling of the current piece
  always_comb begin
    next_seg = par_seg;
    case (k_nxt)
      2'd1: begin
        next_seg.x1 = par_pts.xa;
        next_seg.y1 = par_pts.ya;
        next_seg.x2 = par_pts.xm;
        next_seg.y2 = par_pts.ym;
      end
      2'd2: begin
        next_seg.x1 = par_pts.xm;
        next_seg.y1 = par_pts.ym;
        next_seg.x2 = par_pts.xb;
        next_seg.y2 = par_pts.yb;
      end
      default: begin
        next_seg.x1 = par_pts.xb;
        next_seg.y1 = par_pts.yb;
        next_seg.x2 = par_seg.x2;
        next_seg.y2 = par_seg.y2;
      end
    endcase
  end

  assign split_start = (state_r == ST_DESC) && (sp_r < lvl_r);

  kcsg_split u_split (
    .clk   (clk),
    .rst_n (rst_n),
    .start (split_start),
    .seg   (cur_seg),
    .rsp   (split_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      level_r <= kcsg_pkg::KOCH_LEVEL_RESET;
      sp_r    <= '0;
      lvl_r   <= '0;
      cnt_r   <= '0;
      total_r <= CNT_W'(1);
      for (int i = 0; i < STACK_D; i++) begin
        child_r[i] <= '0;
      end
    end else begin
      if (cfg_wr) level_r <= pwdata[kcsg_pkg::LEVEL_W-1:0];
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            sp_r    <= '0;
            cnt_r   <= '0;
            lvl_r   <= lvl_clamp;
            total_r <= CNT_W'(1) << {lvl_clamp, 1'b0};
            state_r <= ST_DESC;
          end
        end
        ST_DESC: begin
          if (sp_r < lvl_r) begin
            state_r <= ST_SPLIT;
          end else begin
            state_r <= ST_OUT;
          end
        end
        ST_SPLIT: begin
          if (split_rsp.done) begin
            child_r[sp_r] <= '0;
            sp_r          <= sp_inc;
            state_r       <= ST_DESC;
          end
        end
        ST_OUT: begin
          if (out_fire) begin
            cnt_r   <= cnt_r + 1'b1;
            state_r <= final_r ? ST_IDLE : ST_ASC;
          end
        end
        ST_ASC: begin
          if (sp_r == '0) begin
            state_r <= ST_IDLE;
          end else if (child_r[sp_dec] == kcsg_pkg::CHILD_LAST) begin
            sp_r <= sp_dec;
          end else begin
            child_r[sp_dec] <= k_nxt;
            state_r         <= ST_DESC;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // segment stack, split cache and output item registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      frame_r[0] <= '{x1: in_start_x, y1: in_start_y, x2: in_end_x, y2: in_end_y};
    end
    if (state_r == ST_SPLIT && split_rsp.done) begin
      cache_r[sp_r]  <= split_rsp.pts;
      frame_r[sp_inc] <= '{x1: cur_seg.x1, y1: cur_seg.y1,
                          x2: split_rsp.pts.xa, y2: split_rsp.pts.ya};
    end
    if (state_r == ST_ASC && sp_r != '0 && child_r[sp_dec] != kcsg_pkg::CHILD_LAST) begin
      frame_r[sp_r] <= next_seg;
    end
    if (state_r == ST_DESC && !(sp_r < lvl_r)) begin
      out_seg_r <= cur_seg;
      final_r   <= ((cnt_r + 1'b1) == total_r);
    end
  end

  assign out_piece_x1    = out_seg_r.x1;
  assign out_piece_y1    = out_seg_r.y1;
  assign out_piece_x2    = out_seg_r.x2;
  assign out_piece_y2    = out_seg_r.y2;
  assign out_final_piece = final_r;

  `KCSG_ASSERT_ALWAYS(a_ready_excl, !(in_ready && out_valid), "input ready while item pending")
  `KCSG_ASSERT_IMP(a_sp_bound, state_r != ST_IDLE, sp_r <= lvl_r, "stack pointer past level")
  `KCSG_ASSERT_IMP(a_cnt_bound, out_valid, cnt_r < total_r, "more pieces than 4^level")
  `KCSG_ASSERT_NEXT(a_final_idle, out_fire && out_final_piece, in_ready, "no idle after final")

endmodule

`default_nettype wire

@@ test/kcsg_piece_checker.sv @@
// Checker for the Koch curve segment generator: predicts every piece and compares it.
`timescale 1ns / 1ps

module kcsg_piece_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  kcsg_pkg::coord_t                in_start_x,
  input  kcsg_pkg::coord_t                in_start_y,
  input  kcsg_pkg::coord_t                in_end_x,
  input  kcsg_pkg::coord_t                in_end_y,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  kcsg_pkg::coord_t                out_piece_x1,
  input  kcsg_pkg::coord_t                out_piece_y1,
  input  kcsg_pkg::coord_t                out_piece_x2,
  input  kcsg_pkg::coord_t                out_piece_y2,
  input  logic                            out_final_piece,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [kcsg_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [kcsg_pkg::CFG_DATA_W-1:0] pwdata,
  input  logic [kcsg_pkg::CFG_DATA_W-1:0] prdata,
  input  logic                            pready,
  output int                              mismatch_count,
  output int                              pieces_due_count,
  output int                              pieces_seen
);

  localparam int REPORT_CAP = 100;

  typedef struct packed {
    kcsg_pkg::kcsg_seg_t seg;
    logic                last_flag;
  } piece_t;

  piece_t                       pieces_due[$];
  logic [kcsg_pkg::LEVEL_W-1:0] koch_level;

  function automatic longint sat_coord(input longint v);
    if (v > longint'(kcsg_pkg::COORD_MAX)) return longint'(kcsg_pkg::COORD_MAX);
    if (v < longint'(kcsg_pkg::COORD_MIN)) return longint'(kcsg_pkg::COORD_MIN);
    return v;
  endfunction

  // Expand level by level; keeping child order gives the depth-first order.
  function automatic void koch_expand(input kcsg_pkg::kcsg_seg_t root,
                                      input logic [kcsg_pkg::LEVEL_W-1:0] lvl);
    kcsg_pkg::kcsg_seg_t level_segs[$];
    kcsg_pkg::kcsg_seg_t next_segs[$];
    longint      px[5];
    longint      py[5];
    longint      dx, dy, mx, my, sx, sy, q16;
    int unsigned depth;
    piece_t      due;
    q16 = longint'(1) << kcsg_pkg::SQRT3_SHIFT;
    depth = (lvl > kcsg_pkg::MAX_DEPTH_DEF) ? kcsg_pkg::MAX_DEPTH_DEF : lvl;
    level_segs.push_back(root);
    repeat (depth) begin
      next_segs.delete();
      for (int i = 0; i < level_segs.size(); i++) begin
        px[0] = $signed(level_segs[i].x1);
        py[0] = $signed(level_segs[i].y1);
        px[4] = $signed(level_segs[i].x2);
        py[4] = $signed(level_segs[i].y2);
        dx = (px[4] - px[0]) / 3;
        dy = (py[4] - py[0]) / 3;
        px[1] = sat_coord(px[0] + dx);
        py[1] = sat_coord(py[0] + dy);
        px[3] = sat_coord(px[4] - dx);
        py[3] = sat_coord(py[4] - dy);
        mx = (px[1] + px[3]) / 2;
        my = (py[1] + py[3]) / 2;
        sx = ((py[3] - py[1]) * longint'(kcsg_pkg::SQRT3_HALF)) / q16;
        sy = ((px[3] - px[1]) * longint'(kcsg_pkg::SQRT3_HALF)) / q16;
        px[2] = sat_coord(mx - sx);
        py[2] = sat_coord(my + sy);
        for (int k = 0; k < 4; k++)
          next_segs.push_back({kcsg_pkg::coord_t'(px[k]), kcsg_pkg::coord_t'(py[k]),
                               kcsg_pkg::coord_t'(px[k+1]), kcsg_pkg::coord_t'(py[k+1])});
      end
      level_segs = next_segs;
    end
    for (int i = 0; i < level_segs.size(); i++) begin
      due.seg       = level_segs[i];
      due.last_flag = (i == level_segs.size() - 1);
      pieces_due.push_back(due);
    end
  endfunction

  task automatic report_field(input string name, input longint want, input longint got);
    mismatch_count++;
    if (mismatch_count <= REPORT_CAP)
      $display("%0t ns: mismatch on %s: expected %0d, got %0d", $time, name, want, got);
  endtask

  always @(posedge clk) begin : watch
    piece_t due;
    if (!rst_n) begin
      koch_level = kcsg_pkg::KOCH_LEVEL_RESET;
      pieces_due.delete();
      mismatch_count = 0;
      pieces_seen = 0;
    end else begin
      if (psel && penable && pready && paddr[2] == kcsg_pkg::REG_KOCH_LEVEL) begin
        if (pwrite)
          koch_level = pwdata[kcsg_pkg::LEVEL_W-1:0];
        else if (prdata !== kcsg_pkg::CFG_DATA_W'(koch_level))
          report_field("koch_level readback", koch_level, prdata);
      end
      if (in_valid && in_ready)
        koch_expand({in_start_x, in_start_y, in_end_x, in_end_y}, koch_level);
      if (out_valid && out_ready) begin
        pieces_seen++;
        if (pieces_due.size() == 0) begin
          mismatch_count++;
          $display("%0t ns: unexpected piece (%0d,%0d)->(%0d,%0d), expected none", $time,
                   out_piece_x1, out_piece_y1, out_piece_x2, out_piece_y2);
        end else begin
          due = pieces_due.pop_front();
          if (out_piece_x1 !== due.seg.x1) report_field("piece_x1", due.seg.x1, out_piece_x1);
          if (out_piece_y1 !== due.seg.y1) report_field("piece_y1", due.seg.y1, out_piece_y1);
          if (out_piece_x2 !== due.seg.x2) report_field("piece_x2", due.seg.x2, out_piece_x2);
          if (out_piece_y2 !== due.seg.y2) report_field("piece_y2", due.seg.y2, out_piece_y2);
          if (out_final_piece !== due.last_flag)
            report_field("final_piece", due.last_flag, out_final_piece);
        end
      end
    end
    pieces_due_count = pieces_due.size();
  end

endmodule

@@ test/koch_curve_segment_generator_unit_tb.sv @@
// Testbench top for the Koch curve segment generator: stimulus, idling and verdict.
`timescale 1ns / 1ps

module koch_curve_segment_generator_unit_tb;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 52;

  localparam logic [kcsg_pkg::CFG_ADDR_W-1:0] LEVEL_ADDR    =
    {kcsg_pkg::REG_KOCH_LEVEL, 2'b00};
  localparam logic [kcsg_pkg::CFG_ADDR_W-1:0] UNMAPPED_ADDR =
    {~kcsg_pkg::REG_KOCH_LEVEL, 2'b00};

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_ready;
  kcsg_pkg::coord_t                in_start_x, in_start_y, in_end_x, in_end_y;
  logic                            out_valid;
  logic                            out_ready;
  kcsg_pkg::coord_t                out_piece_x1, out_piece_y1, out_piece_x2, out_piece_y2;
  logic                            out_final_piece;
  logic                            psel, penable, pwrite;
  logic [kcsg_pkg::CFG_ADDR_W-1:0] paddr;
  logic [kcsg_pkg::CFG_DATA_W-1:0] pwdata;
  logic [kcsg_pkg::CFG_DATA_W-1:0] prdata;
  logic                            pready;

  int mismatch_count;
  int pieces_due_count;
  int pieces_seen;
  int items_sent;
  int idle_cycles;
  int tx_idle_pct;
  int rx_stall_pct;

  int unsigned phase_level [PHASES] = '{2, 3, 1, 3, 0, 2, 3, 1};

  koch_curve_segment_generator_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_start_x      (in_start_x),
    .in_start_y      (in_start_y),
    .in_end_x        (in_end_x),
    .in_end_y        (in_end_y),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_piece_x1    (out_piece_x1),
    .out_piece_y1    (out_piece_y1),
    .out_piece_x2    (out_piece_x2),
    .out_piece_y2    (out_piece_y2),
    .out_final_piece (out_final_piece),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  kcsg_piece_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t ns: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(input kcsg_pkg::coord_t sx, input kcsg_pkg::coord_t sy,
                           input kcsg_pkg::coord_t ex, input kcsg_pkg::coord_t ey);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_start_x <= sx;
    in_start_y <= sy;
    in_end_x   <= ex;
    in_end_y   <= ey;
    @(posedge clk);
    while (!(in_valid && in_ready)) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // Block is idle once all pieces are out and it takes items again.
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pieces_due_count != 0 || !in_ready) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [kcsg_pkg::CFG_ADDR_W-1:0] addr,
                            input logic [kcsg_pkg::CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_level(input int unsigned lvl);
    settle();
    apb_access(1'b1, LEVEL_ADDR, ($urandom() & ~32'h3) | lvl);
    apb_access(1'b0, LEVEL_ADDR, '0);
  endtask

  function automatic kcsg_pkg::kcsg_seg_t rand_segment();
    kcsg_pkg::kcsg_seg_t s;
    kcsg_pkg::coord_t    pick [5];
    int unsigned         sel;
    pick = '{kcsg_pkg::COORD_MIN, kcsg_pkg::COORD_MAX, 20'sd0, -20'sd1, 20'sd1};
    sel = $urandom_range(99);
    if (sel < 55) begin
      s.x1 = kcsg_pkg::coord_t'($urandom());
      s.y1 = kcsg_pkg::coord_t'($urandom());
      s.x2 = kcsg_pkg::coord_t'($urandom());
      s.y2 = kcsg_pkg::coord_t'($urandom());
    end else if (sel < 80) begin
      // short segment around a mid-range point
      s.x1 = kcsg_pkg::coord_t'($signed(19'($urandom())));
      s.y1 = kcsg_pkg::coord_t'($signed(19'($urandom())));
      s.x2 = s.x1 + kcsg_pkg::coord_t'($urandom_range(2047)) - 20'sd1024;
      s.y2 = s.y1 + kcsg_pkg::coord_t'($urandom_range(2047)) - 20'sd1024;
    end else if (sel < 92) begin
      s.x1 = pick[$urandom_range(4)];
      s.y1 = pick[$urandom_range(4)];
      s.x2 = pick[$urandom_range(4)];
      s.y2 = pick[$urandom_range(4)];
    end else begin
      s.x1 = $urandom_range(1) ? kcsg_pkg::COORD_MAX : kcsg_pkg::COORD_MIN;
      s.y1 = kcsg_pkg::coord_t'($urandom());
      s.x2 = kcsg_pkg::coord_t'($urandom());
      s.y2 = $urandom_range(1) ? kcsg_pkg::COORD_MAX : kcsg_pkg::COORD_MIN;
    end
    return s;
  endfunction

  initial begin : stimulus
    kcsg_pkg::kcsg_seg_t seg;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_start_x   = '0;
    in_start_y   = '0;
    in_end_x     = '0;
    in_end_y     = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    items_sent   = 0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    settle();

    // reset level: full depth, bumps pushed past every edge
    send_item(20'sd0, 20'sd0, 20'sd0, 20'sd0);
    send_item(kcsg_pkg::COORD_MIN, kcsg_pkg::COORD_MIN, kcsg_pkg::COORD_MAX,
              kcsg_pkg::COORD_MAX);
    send_item(kcsg_pkg::COORD_MAX, kcsg_pkg::COORD_MIN, kcsg_pkg::COORD_MIN,
              kcsg_pkg::COORD_MAX);
    send_item(kcsg_pkg::COORD_MIN, kcsg_pkg::COORD_MAX, kcsg_pkg::COORD_MAX,
              kcsg_pkg::COORD_MAX);
    send_item(kcsg_pkg::COORD_MAX, kcsg_pkg::COORD_MAX, kcsg_pkg::COORD_MAX,
              kcsg_pkg::COORD_MIN);
    send_item(kcsg_pkg::COORD_MAX, kcsg_pkg::COORD_MIN, kcsg_pkg::COORD_MIN,
              kcsg_pkg::COORD_MIN);
    send_item(kcsg_pkg::COORD_MIN, kcsg_pkg::COORD_MIN, kcsg_pkg::COORD_MIN,
              kcsg_pkg::COORD_MAX);
    send_item(-20'sd1, 20'sd1, 20'sd1, -20'sd1);

    // level zero passes the segment through
    set_level(0);
    send_item(kcsg_pkg::COORD_MIN, kcsg_pkg::COORD_MAX, kcsg_pkg::COORD_MAX,
              kcsg_pkg::COORD_MIN);
    send_item(20'sd0, -20'sd1, -20'sd1, 20'sd0);

    // write outside the register map must leave the level alone
    settle();
    apb_access(1'b1, UNMAPPED_ADDR, 32'd3);
    apb_access(1'b0, LEVEL_ADDR, '0);
    send_item(20'sd1000, 20'sd2000, -20'sd3000, 20'sd5);

    set_level(1);
    send_item(20'sd0, 20'sd0, 20'sd768, 20'sd0);
    send_item(kcsg_pkg::COORD_MIN, kcsg_pkg::COORD_MAX, kcsg_pkg::COORD_MAX,
              kcsg_pkg::COORD_MAX);
    seg = rand_segment();
    send_item(seg.x1, seg.y1, seg.x2, seg.y2);

    set_level(2);
    send_item(20'sd0, 20'sd0, 20'sd0, kcsg_pkg::COORD_MAX);
    send_item(kcsg_pkg::COORD_MAX, kcsg_pkg::COORD_MIN, kcsg_pkg::COORD_MIN,
              kcsg_pkg::COORD_MAX);
    send_item(kcsg_pkg::COORD_MAX, kcsg_pkg::COORD_MAX, kcsg_pkg::COORD_MIN,
              kcsg_pkg::COORD_MIN);

    for (int p = 0; p < PHASES; p++) begin
      set_level(phase_level[p]);
      case (p % 4)
        1:       begin tx_idle_pct = 53; rx_stall_pct = 0;  end
        2:       begin tx_idle_pct = 0;  rx_stall_pct = 53; end
        3:       begin tx_idle_pct = 12; rx_stall_pct = 12; end
        default: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        seg = rand_segment();
        send_item(seg.x1, seg.y1, seg.x2, seg.y2);
      end
    end

    settle();
    repeat (32) @(negedge clk);
    $display("Sent %0d segments at levels 0 to 3 and checked %0d pieces,", items_sent,
             pieces_seen);
    $display("with sender gaps, receiver stalls and coordinates saturating at the edges.");
    if (mismatch_count == 0 && pieces_due_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
